FILE: src/pts_pkg.sv
// shared types, widths and helper functions for the packed tanimoto similarity block
// no dependencies
package pts_pkg;

  localparam int WORD_W    = 64;
  localparam int POP_W     = 7;   // popcount of one 64-bit word
  localparam int COUNT_W   = 12;  // saturating bit counters
  localparam int UNI_W     = COUNT_W + 1;
  localparam int REM_W     = UNI_W + 1;
  localparam int SIM_W     = 17;  // 1.16 unsigned fixed point
  localparam int FRAC_W    = 16;
  localparam int NUM_W     = COUNT_W + FRAC_W;  // intersection scaled by 1.0
  localparam int DIV_STEPS = NUM_W;
  localparam int STEP_W    = 5;
  localparam int IDX_OUT_W = 16;

  localparam int DEFAULT_MAX_WORDS      = 32;
  localparam int DEFAULT_ROW_INDEX_BITS = 16;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_ROW   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_SETUP,
    ST_DIV,
    ST_FIN
  } pts_state_t;

  function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      n = n + POP_W'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [POP_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + (COUNT_W + 1)'(b);
    return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
  endfunction

endpackage

FILE: src/packed_tanimoto_similarity.sv
// a row's last word passes the accumulate, setup, divide and finish states before its
// score is registered at the output; a row whose length differs from the query skips
// the divide state; other words give no result. Each word is accepted and then popcounted
// before the next is taken; a matching row end uses the 28-step shared restoring divider,
// and finish waits while the output register still holds an unaccepted score
// reset: synchronous active-low rst_n clears counters, query length/ones and output valid
module packed_tanimoto_similarity #(
  parameter int MAX_WORDS      = pts_pkg::DEFAULT_MAX_WORDS,
  parameter int ROW_INDEX_BITS = pts_pkg::DEFAULT_ROW_INDEX_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [pts_pkg::WORD_W-1:0]      in_word,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pts_pkg::IDX_OUT_W-1:0]   out_row_index,
  output logic [pts_pkg::COUNT_W-1:0]     out_intersection,
  output logic [pts_pkg::COUNT_W-1:0]     out_union_count,
  output logic [pts_pkg::SIM_W-1:0]       out_similarity,
  output logic                            out_status
);

  localparam int AW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CNT_W = $clog2(MAX_WORDS + 2);
  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_WORDS);
  localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(MAX_WORDS + 1);

  pts_pkg::pts_state_t state_r, state_nxt;

  logic [pts_pkg::WORD_W-1:0] mem [MAX_WORDS];
  logic [pts_pkg::WORD_W-1:0] rd_r;
  logic [pts_pkg::WORD_W-1:0] word_r;
  logic                       op_r, last_r, en_r, qv_r;

  logic [CNT_W-1:0]            load_ptr_r, row_cnt_r, query_len_r;
  logic [pts_pkg::COUNT_W-1:0] load_ones_r, query_ones_r, row_ones_r, row_and_r;
  logic [ROW_INDEX_BITS-1:0]   row_idx_r;

  logic [pts_pkg::UNI_W-1:0]   div_r;
  logic [pts_pkg::REM_W-1:0]   rem_r;
  logic [pts_pkg::NUM_W-1:0]   num_r;
  logic [pts_pkg::SIM_W-1:0]   quo_r;
  logic [pts_pkg::STEP_W-1:0]  step_r;

  logic [pts_pkg::IDX_OUT_W-1:0] out_row_index_r;
  logic [pts_pkg::COUNT_W-1:0]   out_intersection_r, out_union_r;
  logic [pts_pkg::SIM_W-1:0]     out_sim_r;
  logic                          out_status_r, out_valid_r;

  logic                        accept, fin_load, div_last, bad, rem_ge;
  logic [pts_pkg::UNI_W-1:0]   uni_sum;
  logic [pts_pkg::REM_W-1:0]   rem_cand, rem_diff, rem_sel;
  logic [pts_pkg::POP_W-1:0]   pop_word, pop_and;
  logic [pts_pkg::COUNT_W-1:0] load_ones_sum;
  logic [ROW_INDEX_BITS+pts_pkg::IDX_OUT_W-1:0] idx_ext;

  assign accept = in_valid && in_ready;

  // shared datapath pieces
  assign pop_word      = pts_pkg::popcount64(word_r);
  assign pop_and       = pts_pkg::popcount64(word_r & (qv_r ? rd_r : '0));
  assign load_ones_sum = en_r ? pts_pkg::sat_add(load_ones_r, pop_word) : load_ones_r;
  assign uni_sum  = {1'b0, row_ones_r} + {1'b0, query_ones_r} - {1'b0, row_and_r};
  assign bad      = (row_cnt_r != query_len_r);
  // full long division, only the low quotient bits are kept
  assign rem_cand = {rem_r[pts_pkg::REM_W-2:0], num_r[pts_pkg::NUM_W-1]};
  assign rem_ge   = (rem_cand >= {1'b0, div_r});
  assign rem_diff = rem_cand - {1'b0, div_r};
  assign rem_sel  = rem_ge ? rem_diff : rem_cand;
  assign div_last = (step_r == pts_pkg::STEP_W'(pts_pkg::DIV_STEPS - 1));
  assign idx_ext  = {{pts_pkg::IDX_OUT_W{1'b0}}, row_idx_r};

  // control decode
  always_comb begin
    in_ready = 1'b0;
    fin_load = 1'b0;
    unique case (state_r)
      pts_pkg::ST_IDLE: in_ready = 1'b1;
      pts_pkg::ST_FIN:  fin_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pts_pkg::ST_IDLE:  if (accept) state_nxt = pts_pkg::ST_ACC;
      pts_pkg::ST_ACC: begin
        if (op_r == pts_pkg::OP_ROW && last_r) state_nxt = pts_pkg::ST_SETUP;
        else state_nxt = pts_pkg::ST_IDLE;
      end
      pts_pkg::ST_SETUP: state_nxt = bad ? pts_pkg::ST_FIN : pts_pkg::ST_DIV;
      pts_pkg::ST_DIV:   if (div_last) state_nxt = pts_pkg::ST_FIN;
      pts_pkg::ST_FIN:   if (fin_load) state_nxt = pts_pkg::ST_IDLE;
      default:           state_nxt = pts_pkg::ST_IDLE;
    endcase
  end

  // query store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_op == pts_pkg::OP_QUERY && load_ptr_r < MAX_CNT) begin
        mem[load_ptr_r[AW-1:0]] <= in_word;
      end
      rd_r <= mem[row_cnt_r[AW-1:0]];
    end
  end

  // captured request and divider datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= in_word;
      op_r   <= in_op;
      last_r <= in_last;
      if (in_op == pts_pkg::OP_QUERY) begin
        en_r <= (load_ptr_r < MAX_CNT);
        qv_r <= 1'b0;
      end else begin
        en_r <= (row_cnt_r < MAX_CNT);
        qv_r <= (row_cnt_r < query_len_r);
      end
    end
    if (state_r == pts_pkg::ST_SETUP) begin
      div_r  <= (uni_sum == '0) ? pts_pkg::UNI_W'(1) : uni_sum;
      rem_r  <= '0;
      num_r  <= {row_and_r, {pts_pkg::FRAC_W{1'b0}}};
      quo_r  <= '0;
      step_r <= '0;
    end else if (state_r == pts_pkg::ST_DIV) begin
      rem_r  <= rem_sel;
      num_r  <= {num_r[pts_pkg::NUM_W-2:0], 1'b0};
      quo_r  <= {quo_r[pts_pkg::SIM_W-2:0], rem_ge};
      step_r <= step_r + pts_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_row_index_r    <= idx_ext[pts_pkg::IDX_OUT_W-1:0];
      out_intersection_r <= row_and_r;
      out_union_r        <= uni_sum[pts_pkg::COUNT_W] ? {pts_pkg::COUNT_W{1'b1}}
                                                      : uni_sum[pts_pkg::COUNT_W-1:0];
      out_sim_r          <= bad ? '0 : quo_r;
      out_status_r       <= bad;
    end
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pts_pkg::ST_IDLE;
      load_ptr_r   <= '0;
      load_ones_r  <= '0;
      query_len_r  <= '0;
      query_ones_r <= '0;
      row_cnt_r    <= '0;
      row_ones_r   <= '0;
      row_and_r    <= '0;
      row_idx_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        if (in_op == pts_pkg::OP_QUERY) begin
          if (load_ptr_r < LIMIT_CNT) load_ptr_r <= load_ptr_r + CNT_W'(1);
        end else begin
          if (row_cnt_r < LIMIT_CNT) row_cnt_r <= row_cnt_r + CNT_W'(1);
        end
      end
      if (state_r == pts_pkg::ST_ACC) begin
        if (op_r == pts_pkg::OP_QUERY) begin
          if (last_r) begin
            // commit the query and restart row numbering
            query_len_r  <= load_ptr_r;
            query_ones_r <= load_ones_sum;
            load_ptr_r   <= '0;
            load_ones_r  <= '0;
            row_cnt_r    <= '0;
            row_ones_r   <= '0;
            row_and_r    <= '0;
            row_idx_r    <= '0;
          end else begin
            load_ones_r <= load_ones_sum;
          end
        end else if (en_r) begin
          row_ones_r <= pts_pkg::sat_add(row_ones_r, pop_word);
          row_and_r  <= pts_pkg::sat_add(row_and_r, pop_and);
        end
      end
      if (fin_load) begin
        row_idx_r  <= row_idx_r + ROW_INDEX_BITS'(1);
        row_cnt_r  <= '0;
        row_ones_r <= '0;
        row_and_r  <= '0;
      end
      if (fin_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_index    = out_row_index_r;
  assign out_intersection = out_intersection_r;
  assign out_union_count  = out_union_r;
  assign out_similarity   = out_sim_r;
  assign out_status       = out_status_r;

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> out_sim_r == '0)
    else $error("length mismatch with nonzero similarity");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_sim_r)
                                     && $stable(out_row_index_r)))
    else $error("score changed while stalled");

  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == pts_pkg::ST_FIN))
    else $error("result raised outside finish state");

  a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pts_pkg::ST_DIV) |-> step_r < pts_pkg::STEP_W'(pts_pkg::DIV_STEPS))
    else $error("divider step count overrun");

endmodule
